/* hdl/ctce_pkg.sv */
// Shared types and constants of the text cell cursor engine.
// Used by ctce_core, ctce_opq and text_cell_cursor_engine; no dependencies.
`default_nettype none

package ctce_pkg;

	// Glyph set size: the number of codes from first_code on that have a glyph
	localparam int unsigned GLYPH_COUNT = 96;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	// Config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_COL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_EN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_SP  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ADV   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE = 3'd7;

	// Operation kinds
	localparam logic [2:0] OP_WRITE       = 3'd0;
	localparam logic [2:0] OP_SCROLL_UP   = 3'd1;
	localparam logic [2:0] OP_SCROLL_DOWN = 3'd2;
	localparam logic [2:0] OP_CURSOR      = 3'd3;
	localparam logic [2:0] OP_ERROR       = 3'd4;

	// Request types
	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	// Control codes
	localparam logic [7:0] CODE_BS    = 8'h08;
	localparam logic [7:0] CODE_CR    = 8'h0D;
	localparam logic [7:0] CODE_DEL   = 8'h7F;
	localparam logic [7:0] CODE_BLANK = 8'h20;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_code;
		logic [7:0] new_col;
		logic [7:0] new_row;
	} req_word_t;

	typedef struct packed {
		logic [2:0] op_kind;
		logic [7:0] glyph_index;
		logic [7:0] cell_col;
		logic [7:0] cell_row;
		logic [7:0] cursor_col;
		logic [7:0] cursor_row;
		logic       last_op;
	} op_word_t;

	typedef struct packed {
		logic [7:0] first_col;
		logic [7:0] first_row;
		logic [7:0] last_col;
		logic [7:0] last_row;
		logic       scroll_enable;
		logic       double_spacing;
		logic       auto_advance;
		logic [7:0] first_code;
	} cfg_t;

	typedef struct packed {
		logic [7:0] col;
		logic [7:0] row;
	} cursor_t;

	// All words caused by one request, oldest in entry 0
	typedef struct packed {
		op_word_t [2:0] res;
		logic [1:0]     cnt;
	} bundle_t;

endpackage

`default_nettype wire

/* hdl/ctce_core.sv */
// Request decode and cursor arithmetic: one request in, up to three op words out.
// Combinational; depends on ctce_pkg.
`default_nettype none

module ctce_core import ctce_pkg::*; (
	input  wire req_word_t req,
	input  wire cfg_t      cfg,
	input  wire cursor_t   cur,
	output bundle_t        bnd,
	output cursor_t        nxt
);

	// one vertical step: {scroll, new row}
	function automatic logic [8:0] vstep(input logic [7:0] row, input logic [7:0] edge_r,
			input logic [7:0] wrap_r, input logic up, input logic sc_en);
		logic [8:0] r;
		if (row == edge_r) begin
			r = sc_en ? {1'b1, row} : {1'b0, wrap_r};
		end else begin
			r = {1'b0, up ? row - 8'd1 : row + 8'd1};
		end
		return r;
	endfunction

	function automatic logic glyph_ok(input logic [7:0] code, input logic [7:0] base);
		logic [7:0] diff;
		diff = code - base;
		return (code >= base) && ({1'b0, diff} < 9'(GLYPH_COUNT));
	endfunction

	function automatic op_word_t mk(input logic [2:0] kind, input logic [7:0] glyph,
			input logic [7:0] ccol, input logic [7:0] crow,
			input logic [7:0] kcol, input logic [7:0] krow);
		op_word_t w;
		w.op_kind     = kind;
		w.glyph_index = glyph;
		w.cell_col    = ccol;
		w.cell_row    = crow;
		w.cursor_col  = kcol;
		w.cursor_row  = krow;
		w.last_op     = 1'b0;
		return w;
	endfunction

	logic       is_cr, is_bs, is_del, up;
	logic       blank_ok, code_ok, set_ok, bs_wrap, wrap;
	logic [7:0] edge_r, wrap_r, vcol, r1row, r2row, advcol, bcol, brow;
	logic [8:0] st1, st2;
	logic       sc1, sc2;
	logic [1:0] scn;
	op_word_t   e1, e2, sa, sb, wr;
	logic [2:0] kind_sc;

	always_comb begin
		is_cr  = req.char_code == CODE_CR;
		is_bs  = req.char_code == CODE_BS;
		is_del = req.char_code == CODE_DEL;
		up     = is_bs;

		blank_ok = glyph_ok(CODE_BLANK, cfg.first_code);
		code_ok  = glyph_ok(req.char_code, cfg.first_code);
		set_ok   = req.new_col >= cfg.first_col && req.new_col <= cfg.last_col &&
			req.new_row >= cfg.first_row && req.new_row <= cfg.last_row;

		// shared vertical unit, two steps; second only with double spacing
		edge_r = up ? cfg.first_row : cfg.last_row;
		wrap_r = up ? cfg.last_row : cfg.first_row;
		vcol   = up ? cfg.last_col : cfg.first_col;
		st1    = vstep(cur.row, edge_r, wrap_r, up, cfg.scroll_enable);
		sc1    = st1[8];
		r1row  = st1[7:0];
		st2    = vstep(r1row, edge_r, wrap_r, up, cfg.scroll_enable);
		sc2    = cfg.double_spacing & st2[8];
		r2row  = cfg.double_spacing ? st2[7:0] : r1row;

		kind_sc = up ? OP_SCROLL_DOWN : OP_SCROLL_UP;
		e1  = mk(kind_sc, 8'd0, 8'd0, 8'd0, vcol, cur.row);
		e2  = mk(kind_sc, 8'd0, 8'd0, 8'd0, vcol, r1row);
		// a scroll on step one forces a scroll on step two
		sa  = sc1 ? e1 : e2;
		sb  = e2;
		scn = {1'b0, sc1} + {1'b0, sc2};

		bs_wrap = cur.col == cfg.first_col;
		bcol    = bs_wrap ? cfg.last_col : cur.col - 8'd1;
		brow    = bs_wrap ? r2row : cur.row;

		wrap   = cfg.auto_advance && cur.col == cfg.last_col;
		advcol = !cfg.auto_advance ? cur.col : (wrap ? cfg.first_col : cur.col + 8'd1);

		bnd.res    = '0;
		bnd.res[0] = mk(OP_ERROR, 8'd0, 8'd0, 8'd0, cur.col, cur.row);
		bnd.cnt    = 2'd1;
		nxt        = cur;
		wr         = '0;

		if (req.req_type == REQ_SET) begin
			if (set_ok) begin
				nxt.col    = req.new_col;
				nxt.row    = req.new_row;
				bnd.res[0] = mk(OP_CURSOR, 8'd0, 8'd0, 8'd0, req.new_col, req.new_row);
			end
		end else if (is_cr) begin
			nxt.col = cfg.first_col;
			nxt.row = r2row;
			if (scn == 2'd0) begin
				bnd.res[0] = mk(OP_CURSOR, 8'd0, 8'd0, 8'd0, cfg.first_col, r2row);
			end else begin
				bnd.res[0] = sa;
				bnd.res[1] = sb;
				bnd.cnt    = scn;
			end
		end else if (is_bs || is_del) begin
			if (blank_ok) begin
				if (is_del) begin
					bnd.res[0] = mk(OP_WRITE, CODE_BLANK - cfg.first_code,
						cur.col, cur.row, cur.col, cur.row);
				end else begin
					nxt.col = bcol;
					nxt.row = brow;
					wr = mk(OP_WRITE, CODE_BLANK - cfg.first_code, bcol, brow, bcol, brow);
					if (!bs_wrap || scn == 2'd0) begin
						bnd.res[0] = wr;
					end else if (scn == 2'd1) begin
						bnd.res[0] = sa;
						bnd.res[1] = wr;
						bnd.cnt    = 2'd2;
					end else begin
						bnd.res[0] = sa;
						bnd.res[1] = sb;
						bnd.res[2] = wr;
						bnd.cnt    = 2'd3;
					end
				end
			end
		end else if (code_ok) begin
			nxt.col    = advcol;
			nxt.row    = wrap ? r2row : cur.row;
			bnd.res[0] = mk(OP_WRITE, req.char_code - cfg.first_code,
				cur.col, cur.row, advcol, cur.row);
			if (wrap) begin
				bnd.res[1] = sa;
				bnd.res[2] = sb;
				bnd.cnt    = 2'd1 + scn;
			end
			// final word reports the cursor after the whole request
			case (bnd.cnt)
				2'd3: begin
					bnd.res[2].cursor_col = nxt.col;
					bnd.res[2].cursor_row = nxt.row;
				end
				2'd2: begin
					bnd.res[1].cursor_col = nxt.col;
					bnd.res[1].cursor_row = nxt.row;
				end
				default: begin
					bnd.res[0].cursor_col = nxt.col;
					bnd.res[0].cursor_row = nxt.row;
				end
			endcase
		end

		for (int i = 0; i < 3; i++) begin
			bnd.res[i].last_op = 2'(i) == bnd.cnt - 2'd1;
		end
	end

endmodule

`default_nettype wire

/* hdl/ctce_opq.sv */
// Result register: holds the op words of one request and hands them out one a cycle
// as op_ready allows. Depends on ctce_pkg.
`default_nettype none

module ctce_opq import ctce_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire bundle_t bnd,
	input  wire          bnd_valid,
	output logic         bnd_ready,
	output logic         op_valid,
	input  wire          op_ready,
	output op_word_t     op
);

	bundle_t    held_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       take, fin;

	assign take      = busy_q && op_ready;
	assign fin       = take && (idx_q == held_q.cnt - 2'd1);
	assign bnd_ready = !busy_q || fin;
	assign op_valid  = busy_q;
	assign op        = held_q.res[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (bnd_valid && bnd_ready) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_valid && bnd_ready) begin
			held_q <= bnd;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < held_q.cnt)
		else $error("word index beyond bundle count");

	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (op.last_op == (idx_q == held_q.cnt - 2'd1)))
		else $error("last_op flag out of step with word index");

	a_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_ready |=> op_valid && $stable(op))
		else $error("result word changed or dropped while waiting");

endmodule

`default_nettype wire

/* hdl/text_cell_cursor_engine.sv */
// Top level of the text cell cursor engine: config registers, request register,
// cursor state. Depends on ctce_pkg, ctce_core, ctce_opq.
//
//   channel | signals                        | word
//   --------+--------------------------------+------------------------------
//   request | req_valid / req_ready / req    | req_word_t (char or set cursor)
//   result  | op_valid / op_ready / op       | op_word_t (1 to 3 per request)
//   config  | cfg_we / cfg_index / cfg_data  | 8-bit register write, no wait
//
// Cycles: one result word per cycle while op_ready holds. A request is registered at
// acceptance, then decoded and loaded into the result register once that can take it.
// A request producing k words holds the result register until all k are taken (k = 1..3:
// a glyph write plus up to two scrolls, two scrolls for a carriage return, or scrolls
// plus a blank write); single-word requests stream at one per cycle while op_ready holds.
// Stalls: the request register refills in the same cycle the result register takes
// its word, so the request side waits only while that register is full and the
// result register still has words left.
// Reset: clears the cursor to column 0, row 0, loads the config reset values and
// empties both registers.
`default_nettype none

module text_cell_cursor_engine import ctce_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  wire req_word_t       req,
	output logic                 op_valid,
	input  wire                  op_ready,
	output op_word_t             op,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	cursor_t   cur_q;
	req_word_t item_s1;
	logic      valid_s1;

	bundle_t   bnd;
	cursor_t   nxt;
	logic      bnd_ready;
	logic      load;

	// request register advances whenever the result register takes its bundle
	assign load      = valid_s1 && bnd_ready;
	assign req_ready = !valid_s1 || bnd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	// cursor moves when a request's words are committed to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (load) begin
			cur_q <= nxt;
		end
	end

	// config writes; the user must make them only while the engine is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_col      <= 8'd0;
			cfg_q.first_row      <= 8'd0;
			cfg_q.last_col       <= 8'd119;
			cfg_q.last_row       <= 8'd66;
			cfg_q.scroll_enable  <= 1'b1;
			cfg_q.double_spacing <= 1'b0;
			cfg_q.auto_advance   <= 1'b1;
			cfg_q.first_code     <= 8'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_COL:  cfg_q.first_col      <= cfg_data;
				CFG_FIRST_ROW:  cfg_q.first_row      <= cfg_data;
				CFG_LAST_COL:   cfg_q.last_col       <= cfg_data;
				CFG_LAST_ROW:   cfg_q.last_row       <= cfg_data;
				CFG_SCROLL_EN:  cfg_q.scroll_enable  <= cfg_data[0];
				CFG_DOUBLE_SP:  cfg_q.double_spacing <= cfg_data[0];
				CFG_AUTO_ADV:   cfg_q.auto_advance   <= cfg_data[0];
				CFG_FIRST_CODE: cfg_q.first_code     <= cfg_data;
				default: ;
			endcase
		end
	end

	ctce_core u_core (
		.req (item_s1),
		.cfg (cfg_q),
		.cur (cur_q),
		.bnd (bnd),
		.nxt (nxt)
	);

	ctce_opq u_opq (
		.clk       (clk),
		.arst_n    (arst_n),
		.bnd       (bnd),
		.bnd_valid (valid_s1),
		.bnd_ready (bnd_ready),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op)
	);

	a_cursor_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> cur_q == $past(cur_q))
		else $error("cursor changed without a committed request");

	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> bnd.cnt != 2'd0)
		else $error("request decoded to no result words");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req_ready)
		else $error("request side blocked with an empty request register");

endmodule

`default_nettype wire
